// ===== sv/ppmc_pkg.sv =====
`default_nettype none

package ppmc_pkg;

  // mode codes as seen on the result
  localparam logic [2:0] MODE_CODE_SELFTEST = 3'd0;
  localparam logic [2:0] MODE_CODE_STOP     = 3'd1;
  localparam logic [2:0] MODE_CODE_PRESS    = 3'd2;
  localparam logic [2:0] MODE_CODE_HOLD     = 3'd3;
  localparam logic [2:0] MODE_CODE_RELEASE  = 3'd4;

  // operating mode, one-hot
  typedef enum logic [4:0] {
    MODE_SELFTEST = 5'b00001,
    MODE_STOP     = 5'b00010,
    MODE_PRESS    = 5'b00100,
    MODE_HOLD     = 5'b01000,
    MODE_RELEASE  = 5'b10000
  } mode_e;

  // drive state codes
  typedef enum logic [1:0] {
    DRV_STOP  = 2'd0,
    DRV_WAIT  = 2'd1,
    DRV_RUN   = 2'd2,
    DRV_FAULT = 2'd3
  } drive_e;

  // fault codes
  localparam logic [2:0] FC_NONE     = 3'd0;
  localparam logic [2:0] FC_LINK     = 3'd1;
  localparam logic [2:0] FC_DRIVE    = 3'd2;
  localparam logic [2:0] FC_PRESSURE = 3'd3;
  localparam logic [2:0] FC_TEMP     = 3'd4;
  localparam logic [2:0] FC_LIQUID   = 3'd5;
  localparam logic [2:0] FC_MODESET  = 3'd7;

  // sensor fault bit positions
  localparam int unsigned SENS_PRESSURE_BIT = 0;
  localparam int unsigned SENS_TEMP_BIT     = 1;
  localparam int unsigned SENS_LIQUID_BIT   = 2;

  // drive status bit that flags a drive fault
  localparam int unsigned STAT_FAULT_BIT = 3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 3'd4;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration reset values
  localparam logic [15:0] TARGET_RST = 16'd1000;
  localparam logic [15:0] LIMIT_RST  = 16'd2000;
  localparam logic [15:0] HYST_RST   = 16'd30;
  localparam logic [15:0] EMPTY_RST  = 16'd20;
  localparam logic [31:0] SETTLE_RST = 32'd3000;

  // one control pass
  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] pressure;
    logic [15:0] motor_error_code;
    logic [15:0] drive_status;
    logic [2:0]  sensor_bits;
    logic        motor_link_lost;
    logic        selftest_link_ok;
    logic        velocity_mode_ack;
  } in_item_t;

  // result of one pass
  typedef struct packed {
    logic [2:0] system_mode;
    logic       valve_open;
    logic [1:0] drive_state;
    logic       speed_zero_cmd;
    logic       regulator_reset;
    logic       velocity_mode_request;
    logic [2:0] fault_code;
  } out_item_t;

  // one-hot mode to result code
  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    c = MODE_CODE_STOP;
    unique case (m)
      MODE_SELFTEST: c = MODE_CODE_SELFTEST;
      MODE_STOP:     c = MODE_CODE_STOP;
      MODE_PRESS:    c = MODE_CODE_PRESS;
      MODE_HOLD:     c = MODE_CODE_HOLD;
      MODE_RELEASE:  c = MODE_CODE_RELEASE;
      default:       c = MODE_CODE_STOP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ppmc_if.sv =====
`default_nettype none

// input item channel
interface ppmc_in_if;
  import ppmc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result item channel
interface ppmc_out_if;
  import ppmc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/pump_pressure_mode_controller_top.sv =====
`default_nettype none

// the accepted item waits in the input register; its result is registered when it advances
// throughput: one item per cycle without output stalls, single-pass logic between registers
// while a result waits on the output, one more item can still enter the input register
// reset (async, active low) clears mode to self-test, valve closed, drive stop, stop time zero
// and loads the configuration registers with their default values
module pump_pressure_mode_controller_top (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire [ppmc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire [ppmc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  ppmc_in_if.sink                              in_if,
  ppmc_out_if.source                           out_if
);
  import ppmc_pkg::*;

  logic [15:0] target_q, limit_q, hyst_q, empty_q;
  logic [31:0] settle_q;

  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_data_q;
  logic     advance;
  logic     in_accept;

  logic      out_valid_q;
  out_item_t out_data_q;

  mode_e       mode_q, mode_d, prev_q, prev_d;
  logic [31:0] stop_time_q, stop_time_d;
  logic        valve_q, valve_d;
  drive_e      drv_q, drv_d;
  logic        vdone_q, vdone_d;

  logic       spd0, rreset, vreq;
  logic [2:0] fc;
  logic       drive_fault, sens_any, at_hold, entry, settled, ok;
  logic [31:0] elapsed;
  logic [15:0] p;
  logic [2:0]  sens;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      limit_q  <= LIMIT_RST;
      hyst_q   <= HYST_RST;
      empty_q  <= EMPTY_RST;
      settle_q <= SETTLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET: target_q <= cfg_data_i[15:0];
        CFG_LIMIT:  limit_q  <= cfg_data_i[15:0];
        CFG_HYST:   hyst_q   <= cfg_data_i[15:0];
        CFG_EMPTY:  empty_q  <= cfg_data_i[15:0];
        CFG_SETTLE: settle_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // handshake and input register
  assign advance      = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !s1_valid_q || advance;
  assign in_accept    = in_if.valid && in_if.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_if.data;
    end
  end

  // fault decode and pressure compares
  assign p            = s1_data_q.pressure;
  assign sens         = s1_data_q.sensor_bits;
  assign drive_fault  = (|s1_data_q.motor_error_code) || s1_data_q.drive_status[STAT_FAULT_BIT];
  assign sens_any     = |sens;
  // p >= target - hyst, taken signed, as p + hyst >= target
  assign at_hold      = ({1'b0, p} + {1'b0, hyst_q}) >= {1'b0, target_q};
  assign entry        = prev_q != mode_q;
  assign elapsed      = entry ? '0 : (s1_data_q.now_ms - stop_time_q);
  assign settled      = elapsed >= settle_q;

  // one control pass
  always_comb begin
    mode_d      = mode_q;
    prev_d      = prev_q;
    stop_time_d = stop_time_q;
    valve_d     = valve_q;
    drv_d       = drv_q;
    vdone_d     = vdone_q;
    spd0        = 1'b0;
    rreset      = 1'b0;
    vreq        = 1'b0;
    fc          = FC_NONE;
    ok          = 1'b1;

    if (mode_q == MODE_SELFTEST) begin
      if (prev_q != MODE_SELFTEST) begin
        valve_d = 1'b0;
        drv_d   = DRV_WAIT;
        spd0    = 1'b1;
        rreset  = 1'b1;
      end
      prev_d = MODE_SELFTEST;
      if (!s1_data_q.selftest_link_ok || drive_fault || sens_any) begin
        priority if (!s1_data_q.selftest_link_ok) fc = FC_LINK;
        else if (sens[SENS_LIQUID_BIT])           fc = FC_LIQUID;
        else if (sens[SENS_PRESSURE_BIT])         fc = FC_PRESSURE;
        else if (sens[SENS_TEMP_BIT])             fc = FC_TEMP;
        else                                      fc = FC_DRIVE;
        if (drive_fault) begin
          drv_d = DRV_FAULT;
        end
      end else begin
        if (!vdone_q) begin
          vreq = 1'b1;
          if (s1_data_q.velocity_mode_ack) begin
            vdone_d = 1'b1;
          end else begin
            fc = FC_MODESET;
            ok = 1'b0;
          end
        end
        if (ok) begin
          priority if (p >= limit_q) mode_d = MODE_RELEASE;
          else if (at_hold)          mode_d = MODE_HOLD;
          else if (p > empty_q)      mode_d = MODE_PRESS;
          else                       mode_d = MODE_STOP;
        end
      end
    end else if (drive_fault || sens_any || s1_data_q.motor_link_lost) begin
      // fault interlock
      if (mode_q != MODE_STOP) begin
        mode_d  = MODE_STOP;
        valve_d = 1'b0;
        spd0    = 1'b1;
        drv_d   = DRV_FAULT;
        rreset  = 1'b1;
      end
      priority if (s1_data_q.motor_link_lost) fc = FC_LINK;
      else if (drive_fault)                   fc = FC_DRIVE;
      else if (sens[SENS_PRESSURE_BIT])       fc = FC_PRESSURE;
      else if (sens[SENS_TEMP_BIT])           fc = FC_TEMP;
      else                                    fc = FC_LIQUID;
      prev_d = MODE_STOP;
    end else begin
      unique case (mode_q)
        MODE_STOP: begin
          if (entry) begin
            stop_time_d = s1_data_q.now_ms;
            valve_d     = 1'b0;
            spd0        = 1'b1;
            rreset      = 1'b1;
            if (drv_q != DRV_FAULT) drv_d = DRV_STOP;
          end
          if (settled) begin
            priority if (p >= limit_q)     mode_d = MODE_RELEASE;
            else if (!at_hold && p > empty_q) mode_d = MODE_PRESS;
            else                           mode_d = MODE_STOP;
          end
        end
        MODE_PRESS: begin
          if (entry) begin
            rreset = 1'b1;
            drv_d  = DRV_RUN;
          end
          priority if (p >= limit_q) mode_d = MODE_STOP;
          else if (p >= target_q)    mode_d = MODE_HOLD;
          else                       mode_d = MODE_PRESS;
        end
        MODE_HOLD: begin
          if (entry) begin
            rreset = 1'b1;
            drv_d  = DRV_RUN;
          end
          priority if (p >= limit_q) mode_d = MODE_STOP;
          else if (!at_hold)         mode_d = MODE_PRESS;
          else                       mode_d = MODE_HOLD;
        end
        MODE_RELEASE: begin
          if (entry) begin
            valve_d = 1'b1;
            spd0    = 1'b1;
            rreset  = 1'b1;
            if (drv_q != DRV_FAULT) drv_d = DRV_STOP;
          end
          if (p <= empty_q) begin
            valve_d = 1'b0;
            mode_d  = MODE_STOP;
          end
        end
        default: begin
          // corrupt mode code falls back to stop
          mode_d = MODE_STOP;
          spd0   = 1'b1;
          rreset = 1'b1;
          if (drv_q != DRV_FAULT) drv_d = DRV_STOP;
        end
      endcase
      prev_d = mode_q;
    end
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SELFTEST;
      prev_q      <= MODE_SELFTEST;
      stop_time_q <= '0;
      valve_q     <= 1'b0;
      drv_q       <= DRV_STOP;
      vdone_q     <= 1'b0;
    end else if (advance) begin
      mode_q      <= mode_d;
      prev_q      <= prev_d;
      stop_time_q <= stop_time_d;
      valve_q     <= valve_d;
      drv_q       <= drv_d;
      vdone_q     <= vdone_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.system_mode           <= mode_code(mode_d);
      out_data_q.valve_open            <= valve_d;
      out_data_q.drive_state           <= drv_d;
      out_data_q.speed_zero_cmd        <= spd0;
      out_data_q.regulator_reset       <= rreset;
      out_data_q.velocity_mode_request <= vreq;
      out_data_q.fault_code            <= fc;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // valve is only ever open while releasing
  a_valve_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valve_q |-> (mode_q == MODE_RELEASE))
    else $error("valve open outside release mode");

  // self-test is never re-entered
  a_no_selftest_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_SELFTEST) |=> (mode_q != MODE_SELFTEST))
    else $error("mode returned to self-test");

  // velocity mode is requested at most once successfully
  a_vdone_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vdone_q |=> vdone_q)
    else $error("velocity mode done flag cleared");

  // a held item is not lost while the result side stalls
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_data_q)))
    else $error("pending item dropped");

  // the state only moves when a result is produced
  a_state_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(mode_q) && $stable(drv_q)))
    else $error("state changed without a pass");

endmodule

`default_nettype wire

// ===== verif/pump_pressure_mode_controller_top_tb.sv =====
`timescale 1ns / 100ps

module pump_pressure_mode_controller_top_tb;
  import ppmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 188;
  localparam int unsigned DRAIN_CYCLES = 4;
  // index past the last register, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppmc_in_if  in_ch ();
  ppmc_out_if out_ch ();

  pump_pressure_mode_controller_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // controller state as the block should hold it
  logic [2:0]  mode_q;
  logic [2:0]  prev_mode_q;
  logic [31:0] stop_time_q;
  logic        valve_q;
  drive_e      drive_q;
  logic        vel_done_q;
  logic [15:0] cfg_target;
  logic [15:0] cfg_limit;
  logic [15:0] cfg_hyst;
  logic [15:0] cfg_empty;
  logic [31:0] cfg_settle;

  out_item_t   pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          calm_period;
  logic [31:0] now_clock;

  logic [31:0] phase_cfg [0:PHASES-1][0:4] = '{
    '{32'd1000,  32'd2000,  32'd30,    32'd20,    32'd3000},
    '{32'd30000, 32'd50000, 32'd500,   32'd1000,  32'd0},
    '{32'd0,     32'd65535, 32'd65535, 32'd0,     32'd100},
    '{32'd65535, 32'd0,     32'd0,     32'd65535, 32'hFFFF_FFFF},
    '{32'd0,     32'd0,     32'd0,     32'd0,     32'd0},
    '{32'd2000,  32'd4000,  32'd100,   32'd50,    32'd1000}
  };
  logic [CFG_IDX_W-1:0] reg_index [0:4] = '{CFG_TARGET, CFG_LIMIT, CFG_HYST, CFG_EMPTY,
                                             CFG_SETTLE};

  // signed hold threshold: a band wider than the target is always met
  function automatic bit holds_pressure(logic [15:0] p);
    int thr;
    thr = int'(cfg_target) - int'(cfg_hyst);
    return int'(p) >= thr;
  endfunction

  function automatic logic [2:0] sensor_fc(logic [2:0] bits, bit liquid_first);
    if (liquid_first && bits[SENS_LIQUID_BIT]) return FC_LIQUID;
    if (bits[SENS_PRESSURE_BIT]) return FC_PRESSURE;
    if (bits[SENS_TEMP_BIT]) return FC_TEMP;
    return FC_LIQUID;
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    case (idx)
      CFG_TARGET: cfg_target = value[15:0];
      CFG_LIMIT:  cfg_limit  = value[15:0];
      CFG_HYST:   cfg_hyst   = value[15:0];
      CFG_EMPTY:  cfg_empty  = value[15:0];
      CFG_SETTLE: cfg_settle = value;
      default: ;
    endcase
  endfunction

  // one control pass: update the state and build the result item
  function automatic out_item_t predict_pass(in_item_t it);
    out_item_t  r;
    bit         drv_fault;
    bit         sens_fault;
    bit         entry;
    bit         ok;
    logic [2:0] start_mode;
    r          = '0;
    r.fault_code = FC_NONE;
    drv_fault  = (it.motor_error_code != 16'd0) || it.drive_status[STAT_FAULT_BIT];
    sens_fault = it.sensor_bits != 3'd0;
    start_mode = mode_q;
    if (mode_q == MODE_CODE_SELFTEST) begin
      if (prev_mode_q != MODE_CODE_SELFTEST) begin
        valve_q = 1'b0;
        drive_q = DRV_WAIT;
        r.speed_zero_cmd  = 1'b1;
        r.regulator_reset = 1'b1;
      end
      prev_mode_q = MODE_CODE_SELFTEST;
      if (!it.selftest_link_ok || drv_fault || sens_fault) begin
        if (!it.selftest_link_ok) r.fault_code = FC_LINK;
        else if (sens_fault) r.fault_code = sensor_fc(it.sensor_bits, 1'b1);
        else r.fault_code = FC_DRIVE;
        if (drv_fault) drive_q = DRV_FAULT;
      end else begin
        ok = 1'b1;
        if (!vel_done_q) begin
          r.velocity_mode_request = 1'b1;
          if (it.velocity_mode_ack) vel_done_q = 1'b1;
          else begin
            r.fault_code = FC_MODESET;
            ok = 1'b0;
          end
        end
        if (ok) begin
          if (it.pressure >= cfg_limit) mode_q = MODE_CODE_RELEASE;
          else if (holds_pressure(it.pressure)) mode_q = MODE_CODE_HOLD;
          else if (it.pressure > cfg_empty) mode_q = MODE_CODE_PRESS;
          else mode_q = MODE_CODE_STOP;
        end
      end
    end else if (drv_fault || sens_fault || it.motor_link_lost) begin
      // fault interlock, no stop entry actions afterwards
      if (mode_q != MODE_CODE_STOP) begin
        mode_q  = MODE_CODE_STOP;
        valve_q = 1'b0;
        drive_q = DRV_FAULT;
        r.speed_zero_cmd  = 1'b1;
        r.regulator_reset = 1'b1;
      end
      if (it.motor_link_lost) r.fault_code = FC_LINK;
      else if (drv_fault) r.fault_code = FC_DRIVE;
      else r.fault_code = sensor_fc(it.sensor_bits, 1'b0);
      prev_mode_q = MODE_CODE_STOP;
    end else begin
      entry = prev_mode_q != mode_q;
      case (mode_q)
        MODE_CODE_STOP: begin
          if (entry) begin
            stop_time_q = it.now_ms;
            valve_q = 1'b0;
            if (drive_q != DRV_FAULT) drive_q = DRV_STOP;
            r.speed_zero_cmd  = 1'b1;
            r.regulator_reset = 1'b1;
          end
          if (it.now_ms - stop_time_q >= cfg_settle) begin
            if (!holds_pressure(it.pressure) && it.pressure > cfg_empty) mode_q = MODE_CODE_PRESS;
            if (it.pressure >= cfg_limit) mode_q = MODE_CODE_RELEASE;
          end
        end
        MODE_CODE_PRESS: begin
          if (entry) begin
            r.regulator_reset = 1'b1;
            drive_q = DRV_RUN;
          end
          if (it.pressure >= cfg_target) mode_q = MODE_CODE_HOLD;
          if (it.pressure >= cfg_limit) mode_q = MODE_CODE_STOP;
        end
        MODE_CODE_HOLD: begin
          if (entry) begin
            r.regulator_reset = 1'b1;
            drive_q = DRV_RUN;
          end
          if (!holds_pressure(it.pressure)) mode_q = MODE_CODE_PRESS;
          if (it.pressure >= cfg_limit) mode_q = MODE_CODE_STOP;
        end
        MODE_CODE_RELEASE: begin
          if (entry) begin
            valve_q = 1'b1;
            if (drive_q != DRV_FAULT) drive_q = DRV_STOP;
            r.speed_zero_cmd  = 1'b1;
            r.regulator_reset = 1'b1;
          end
          if (it.pressure <= cfg_empty) begin
            valve_q = 1'b0;
            mode_q  = MODE_CODE_STOP;
          end
        end
        default: begin
          mode_q = MODE_CODE_STOP;
          if (drive_q != DRV_FAULT) drive_q = DRV_STOP;
          r.speed_zero_cmd  = 1'b1;
          r.regulator_reset = 1'b1;
        end
      endcase
      prev_mode_q = start_mode;
    end
    r.system_mode = mode_q;
    r.valve_open  = valve_q;
    r.drive_state = drive_q;
    return r;
  endfunction

  function automatic in_item_t pass_in(logic [31:0] now, logic [15:0] p, logic [15:0] err,
                                       logic [15:0] stat, logic [2:0] sens, logic lost,
                                       logic link_ok, logic ack);
    in_item_t it;
    it.now_ms            = now;
    it.pressure          = p;
    it.motor_error_code  = err;
    it.drive_status      = stat;
    it.sensor_bits       = sens;
    it.motor_link_lost   = lost;
    it.selftest_link_ok  = link_ok;
    it.velocity_mode_ack = ack;
    return it;
  endfunction

  function automatic out_item_t pass_out(logic [2:0] mode, logic valve, drive_e drv,
                                         logic spd0, logic rreset, logic vreq,
                                         logic [2:0] fc);
    out_item_t r;
    r.system_mode           = mode;
    r.valve_open            = valve;
    r.drive_state           = drv;
    r.speed_zero_cmd        = spd0;
    r.regulator_reset       = rreset;
    r.velocity_mode_request = vreq;
    r.fault_code            = fc;
    return r;
  endfunction

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_period) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // pressure near one of the thresholds, or anywhere
  function automatic logic [15:0] pick_pressure();
    int base;
    int v;
    case ($urandom_range(0, 7))
      0: base = int'(cfg_target);
      1: base = int'(cfg_target) - int'(cfg_hyst);
      2: base = int'(cfg_limit);
      3: base = int'(cfg_empty);
      4: base = 0;
      5: base = 65535;
      default: base = $urandom_range(0, 65535);
    endcase
    v = base + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // clean passes with advancing time, some faults, some pure noise
  function automatic in_item_t random_pass();
    in_item_t    it;
    int unsigned r;
    int unsigned s;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it = pass_in($urandom, 16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom),
                   1'($urandom), 1'($urandom), 1'($urandom));
      return it;
    end
    s = $urandom_range(0, 99);
    if (s < 80) now_clock += $urandom_range(0, 400);
    else if (s < 95) now_clock += $urandom_range(400, 6000);
    else now_clock = $urandom;
    it = pass_in(now_clock, pick_pressure(), 16'd0, 16'($urandom), 3'd0, 1'b0, 1'($urandom),
                 1'($urandom));
    it.drive_status[STAT_FAULT_BIT] = 1'b0;
    if (r < 16) begin
      case ($urandom_range(0, 3))
        0: it.motor_link_lost = 1'b1;
        1: it.motor_error_code = 16'($urandom_range(1, 65535));
        2: it.drive_status[STAT_FAULT_BIT] = 1'b1;
        default: it.sensor_bits = 3'($urandom_range(1, 7));
      endcase
    end
    return it;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // present one item and wait for its acceptance; valid stays high afterwards
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t calc;
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    calc = predict_pass(it);
    pending_results.push_back(typed ? want : calc);
  endtask

  task automatic load_setting(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    apply_setting(idx, value);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // result side: random stalls, compare against the oldest expectation
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm_period && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    out_item_t got;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: mode %0d fault %0d", got.system_mode,
               got.fault_code);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("system_mode", 32'(want.system_mode), 32'(got.system_mode));
        check_field("valve_open", 32'(want.valve_open), 32'(got.valve_open));
        check_field("drive_state", 32'(want.drive_state), 32'(got.drive_state));
        check_field("speed_zero_cmd", 32'(want.speed_zero_cmd), 32'(got.speed_zero_cmd));
        check_field("regulator_reset", 32'(want.regulator_reset),
                    32'(got.regulator_reset));
        check_field("velocity_mode_request", 32'(want.velocity_mode_request),
                    32'(got.velocity_mode_request));
        check_field("fault_code", 32'(want.fault_code), 32'(got.fault_code));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_TARGET;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    mismatches   = 0;
    cycle_count  = 0;
    stall_left   = 0;
    calm_period  = 1'b0;
    now_clock    = 32'd100;

    // state after reset
    mode_q      = MODE_CODE_SELFTEST;
    prev_mode_q = MODE_CODE_SELFTEST;
    stop_time_q = '0;
    valve_q     = 1'b0;
    drive_q     = DRV_STOP;
    vel_done_q  = 1'b0;
    cfg_target  = TARGET_RST;
    cfg_limit   = LIMIT_RST;
    cfg_hyst    = HYST_RST;
    cfg_empty   = EMPTY_RST;
    cfg_settle  = SETTLE_RST;

    // self-test failures in priority order, then a passing self-test
    directed_rows.push_back('{pass_in(32'd0, 16'd0, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0), 1'b1,
      pass_out(MODE_CODE_SELFTEST, 1'b0, DRV_STOP, 1'b0, 1'b0, 1'b0, FC_LINK)});
    directed_rows.push_back('{pass_in(32'd10, 16'd0, 16'd0, 16'd0, 3'd7, 1'b0, 1'b1, 1'b1), 1'b1,
      pass_out(MODE_CODE_SELFTEST, 1'b0, DRV_STOP, 1'b0, 1'b0, 1'b0, FC_LIQUID)});
    directed_rows.push_back('{pass_in(32'd20, 16'd0, 16'd0, 16'd0, 3'd3, 1'b0, 1'b1, 1'b1), 1'b1,
      pass_out(MODE_CODE_SELFTEST, 1'b0, DRV_STOP, 1'b0, 1'b0, 1'b0, FC_PRESSURE)});
    directed_rows.push_back('{pass_in(32'd30, 16'd0, 16'd0, 16'd0, 3'd2, 1'b0, 1'b1, 1'b1), 1'b1,
      pass_out(MODE_CODE_SELFTEST, 1'b0, DRV_STOP, 1'b0, 1'b0, 1'b0, FC_TEMP)});
    directed_rows.push_back('{pass_in(32'd40, 16'd0, 16'hFFFF, 16'd0, 3'd0, 1'b0, 1'b1, 1'b1),
      1'b1, pass_out(MODE_CODE_SELFTEST, 1'b0, DRV_FAULT, 1'b0, 1'b0, 1'b0, FC_DRIVE)});
    directed_rows.push_back('{pass_in(32'd50, 16'd0, 16'd0, 16'h0008, 3'd0, 1'b0, 1'b1, 1'b1),
      1'b1, pass_out(MODE_CODE_SELFTEST, 1'b0, DRV_FAULT, 1'b0, 1'b0, 1'b0, FC_DRIVE)});
    directed_rows.push_back('{pass_in(32'd60, 16'd500, 16'd0, 16'd0, 3'd0, 1'b0, 1'b1, 1'b0),
      1'b1, pass_out(MODE_CODE_SELFTEST, 1'b0, DRV_FAULT, 1'b0, 1'b0, 1'b1, FC_MODESET)});
    directed_rows.push_back('{pass_in(32'd100, 16'd500, 16'd0, 16'd0, 3'd0, 1'b0, 1'b1, 1'b1),
      1'b0, '0});
    // press, hold and the hysteresis band, over-limit stop
    directed_rows.push_back('{pass_in(32'd150, 16'd500, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    directed_rows.push_back('{pass_in(32'd200, 16'd1000, 16'd0, 16'hFFF7, 3'd0, 1'b0, 1'b0,
      1'b1), 1'b0, '0});
    directed_rows.push_back('{pass_in(32'd250, 16'd990, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    directed_rows.push_back('{pass_in(32'd300, 16'd969, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    directed_rows.push_back('{pass_in(32'd350, 16'd2000, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    // stop entry, settle, then fault interlock on lost link
    directed_rows.push_back('{pass_in(32'd400, 16'd0, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    directed_rows.push_back('{pass_in(32'd3400, 16'd500, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    directed_rows.push_back('{pass_in(32'd3450, 16'd500, 16'd0, 16'd0, 3'd0, 1'b1, 1'b0, 1'b0),
      1'b0, '0});
    // settle measured at the top of the timestamp range, over-limit wins
    directed_rows.push_back('{pass_in(32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0, 3'd0, 1'b0, 1'b1,
      1'b1), 1'b0, '0});
    directed_rows.push_back('{pass_in(32'd0, 16'd1500, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    directed_rows.push_back('{pass_in(32'd10, 16'd20, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    directed_rows.push_back('{pass_in(32'd20, 16'd100, 16'd0, 16'd0, 3'd0, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    // running fault codes while already in stop
    directed_rows.push_back('{pass_in(32'd30, 16'd100, 16'h0001, 16'd0, 3'd1, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    directed_rows.push_back('{pass_in(32'd40, 16'd100, 16'd0, 16'd0, 3'd7, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    directed_rows.push_back('{pass_in(32'd50, 16'd100, 16'd0, 16'd0, 3'd2, 1'b0, 1'b0, 1'b0),
      1'b0, '0});
    directed_rows.push_back('{pass_in(32'd60, 16'd100, 16'd0, 16'd0, 3'd4, 1'b0, 1'b0, 1'b0),
      1'b0, '0});

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 4) begin
        for (int k = 0; k < 4; k++) phase_cfg[ph][k] = $urandom;
        phase_cfg[ph][4] = $urandom_range(0, 8000);
      end
      if (ph == 2) load_setting(CFG_UNUSED, $urandom);
      for (int k = 0; k < 5; k++) load_setting(reg_index[k], phase_cfg[ph][k]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 63) == 0) calm_period = !calm_period;
        send_item(random_pass(), 1'b0, '0);
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== pump_pressure_mode_controller_top.f =====
sv/ppmc_pkg.sv
sv/ppmc_if.sv
sv/pump_pressure_mode_controller_top.sv
verif/pump_pressure_mode_controller_top_tb.sv
